FILE: sv/cartesian_to_polar_deadband_defines.svh
// Assertion macros for the rectangular-to-polar block.
`ifndef CARTESIAN_TO_POLAR_DEADBAND_DEFINES_SVH
`define CARTESIAN_TO_POLAR_DEADBAND_DEFINES_SVH

// Concurrent assertion on a named clock and active-low reset.
`define C2P_ASSERT_ON(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Same, on the block's own clk and rst_n.
`define C2P_ASSERT(lbl, prop, msg) `C2P_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

FILE: sv/c2p_pkg.sv
package c2p_pkg;

    // coordinate width, Q16.16 at 32
    localparam int COORD_WIDTH = 32;

    localparam int MAG_W  = 32;
    localparam int ANG_W  = 31;
    localparam int TOL_W  = 30;
    localparam int AQ_W   = 29;   // first-quadrant angle, [0, pi/2] in Q1.28

    // square root
    localparam int SUM_W  = 2 * COORD_WIDTH;
    localparam int ROOT_W = COORD_WIDTH;
    localparam int REM_W  = ROOT_W + 2;

    // CORDIC
    localparam int NORM_W       = 60;   // larger component normalised into [2^59, 2^60)
    localparam int NORM_STAGES  = 3;
    localparam int CX_W         = 64;
    localparam int Z_W          = 34;
    localparam int CORDIC_STEPS = 31;

    // pipeline depths, counted from the absolute-value stage
    localparam int SQRT_LAT = ROOT_W + 3;
    localparam int ANG_LAT  = NORM_STAGES + CORDIC_STEPS + 1;
    localparam int POST_LAT = 2;
    localparam int PIPE_LAT = (SQRT_LAT > ANG_LAT + POST_LAT) ? SQRT_LAT
                                                             : ANG_LAT + POST_LAT;
    localparam int MAG_PAD  = PIPE_LAT - SQRT_LAT;
    localparam int ANG_PAD  = PIPE_LAT - (ANG_LAT + POST_LAT);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-1:0] abs_t;
    typedef logic        [MAG_W-1:0]       mag_t;
    typedef logic signed [ANG_W-1:0]       bearing_t;
    typedef logic        [TOL_W-1:0]       tol_t;
    typedef logic        [AQ_W-1:0]        fq_angle_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic ax_zero;
        logic ay_zero;
    } quad_t;

    localparam tol_t      PI_Q28      = 30'd843314857;
    localparam fq_angle_t HALF_PI_Q28 = 29'd421657428;
    localparam tol_t      TOL_RESET   = 30'd80531;      // atan(0.0003)

    localparam bearing_t BEARING_MAX = 31'sd843314857;
    localparam bearing_t BEARING_MIN = -31'sd843314857;

    // atan(2^-i), radians * 2^30
    localparam logic signed [Z_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2,         34'sd1
    };

endpackage

FILE: sv/c2p_if.sv
interface c2p_vec_if;
    import c2p_pkg::*;

    logic   valid;
    logic   ready;
    coord_t x_coord;
    coord_t y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_polar_if;
    import c2p_pkg::*;

    logic     valid;
    logic     ready;
    mag_t     magnitude;
    bearing_t bearing;

    modport source (output valid, output magnitude, output bearing, input ready);
    modport sink   (input valid, input magnitude, input bearing, output ready);
endinterface

interface c2p_cfg_if;
    import c2p_pkg::*;

    logic valid;
    logic ready;
    tol_t angle_tolerance;

    modport source (output valid, output angle_tolerance, input ready);
    modport sink   (input valid, input angle_tolerance, output ready);
endinterface

FILE: sv/c2p_isqrt.sv
// Rounded length: squares, sum, one root bit per stage, round and saturate.
module c2p_isqrt (
    input  logic          clk,
    input  logic          en,
    input  c2p_pkg::abs_t ax,
    input  c2p_pkg::abs_t ay,
    output c2p_pkg::mag_t mag
);
    import c2p_pkg::*;

    localparam int RND_W = ROOT_W + 1;

    logic [SUM_W-1:0]  sx_reg;
    logic [SUM_W-1:0]  sy_reg;
    logic [SUM_W-1:0]  s_reg;
    logic [SUM_W-1:0]  s_next;
    logic [REM_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] q_reg   [ROOT_W];
    logic [SUM_W-1:0]  d_reg   [ROOT_W];
    logic [RND_W-1:0]  rnd_next;
    mag_t              mag_next;
    mag_t              mag_reg;

    assign s_next = sx_reg + sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= SUM_W'(ax) * SUM_W'(ax);
            sy_reg <= SUM_W'(ay) * SUM_W'(ay);
            s_reg  <= s_next;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] q_in;
        logic [SUM_W-1:0]  d_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] q_next;
        logic [SUM_W-1:0]  d_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign d_in   = s_reg;
        end
        else
        begin : g_chain
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], d_in[SUM_W-1 -: 2]};
            trial  = {q_in, 2'b01};
            d_next = {d_in[SUM_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                q_next   = {q_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                d_reg[k]   <= d_next;
            end
        end
    end

    // round up when the remainder exceeds the root
    assign rnd_next = RND_W'(q_reg[ROOT_W-1])
                    + RND_W'(rem_reg[ROOT_W-1] > REM_W'(q_reg[ROOT_W-1]));

    if (RND_W > MAG_W)
    begin : g_sat
        assign mag_next = (rnd_next[RND_W-1:MAG_W] != '0) ? '1 : rnd_next[MAG_W-1:0];
    end
    else
    begin : g_ext
        assign mag_next = MAG_W'(rnd_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

FILE: sv/c2p_cordic.sv
// First-quadrant angle: normalise, 31 vectoring steps, round and clamp.
module c2p_cordic (
    input  logic               clk,
    input  logic               en,
    input  c2p_pkg::abs_t      ax,
    input  c2p_pkg::abs_t      ay,
    output c2p_pkg::fq_angle_t angle
);
    import c2p_pkg::*;

    localparam int NORM_SHIFT [2*NORM_STAGES] = '{32, 16, 8, 4, 2, 1};
    localparam logic signed [Z_W-1:0] Z_ROUND = 2;
    localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(HALF_PI_Q28);

    logic [NORM_W-1:0]       nm_reg [NORM_STAGES];
    logic [NORM_W-1:0]       nx_reg [NORM_STAGES];
    logic [NORM_W-1:0]       ny_reg [NORM_STAGES];
    logic signed [CX_W-1:0]  cx_reg [CORDIC_STEPS];
    logic signed [CX_W-1:0]  cy_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]   z_reg  [CORDIC_STEPS];
    logic signed [Z_W-1:0]   z_sum;
    logic signed [Z_W-1:0]   z_q;
    fq_angle_t               angle_next;
    fq_angle_t               angle_reg;

    // true when v still stays below 2^60 after a left shift by k
    function automatic logic fits_shift(input logic [NORM_W-1:0] v, input int unsigned k);
        fits_shift = (v >> (NORM_W - k)) == '0;
    endfunction

    for (genvar s = 0; s < NORM_STAGES; s++)
    begin : g_norm
        logic [NORM_W-1:0] m_in, x_in, y_in;
        logic [NORM_W-1:0] m_mid, x_mid, y_mid;
        logic [NORM_W-1:0] m_next, x_next, y_next;
        logic              t_hi, t_lo;

        if (s == 0)
        begin : g_first
            assign x_in = NORM_W'(ax);
            assign y_in = NORM_W'(ay);
            assign m_in = (ax > ay) ? NORM_W'(ax) : NORM_W'(ay);
        end
        else
        begin : g_chain
            assign x_in = nx_reg[s-1];
            assign y_in = ny_reg[s-1];
            assign m_in = nm_reg[s-1];
        end

        always_comb
        begin
            t_hi   = fits_shift(m_in, NORM_SHIFT[2*s]);
            m_mid  = t_hi ? (m_in << NORM_SHIFT[2*s]) : m_in;
            x_mid  = t_hi ? (x_in << NORM_SHIFT[2*s]) : x_in;
            y_mid  = t_hi ? (y_in << NORM_SHIFT[2*s]) : y_in;
            t_lo   = fits_shift(m_mid, NORM_SHIFT[2*s+1]);
            m_next = t_lo ? (m_mid << NORM_SHIFT[2*s+1]) : m_mid;
            x_next = t_lo ? (x_mid << NORM_SHIFT[2*s+1]) : x_mid;
            y_next = t_lo ? (y_mid << NORM_SHIFT[2*s+1]) : y_mid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nm_reg[s] <= m_next;
                nx_reg[s] <= x_next;
                ny_reg[s] <= y_next;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CX_W-1:0] cx_in, cy_in, dx, dy, cx_next, cy_next;
        logic signed [Z_W-1:0]  z_in, z_next;

        if (i == 0)
        begin : g_first
            assign cx_in = signed'(CX_W'(nx_reg[NORM_STAGES-1]));
            assign cy_in = signed'(CX_W'(ny_reg[NORM_STAGES-1]));
            assign z_in  = '0;
        end
        else
        begin : g_chain
            assign cx_in = cx_reg[i-1];
            assign cy_in = cy_reg[i-1];
            assign z_in  = z_reg[i-1];
        end

        always_comb
        begin
            dx = cy_in >>> i;
            dy = cx_in >>> i;
            if (!cy_in[CX_W-1])
            begin
                cx_next = cx_in + dx;
                cy_next = cy_in - dy;
                z_next  = z_in + ATAN_Q30[i];
            end
            else
            begin
                cx_next = cx_in - dx;
                cy_next = cy_in + dy;
                z_next  = z_in - ATAN_Q30[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i] <= cx_next;
                cy_reg[i] <= cy_next;
                z_reg[i]  <= z_next;
            end
        end
    end

    // Q4.30 to Q1.28, nearest, clamped to [0, pi/2]
    always_comb
    begin
        z_sum = z_reg[CORDIC_STEPS-1] + Z_ROUND;
        z_q   = z_sum >>> 2;
        if (z_q[Z_W-1])
        begin
            angle_next = '0;
        end
        else if (z_q > Z_HALF)
        begin
            angle_next = HALF_PI_Q28;
        end
        else
        begin
            angle_next = z_q[AQ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

FILE: sv/cartesian_to_polar_deadband.sv
// Rectangular-to-polar converter. Each item on vec (x_coord, y_coord, signed
// Q16.16) gives one item on polar: magnitude, the length rounded to nearest in
// unsigned Q16.16, and bearing, atan2(y, x) in radians as signed Q3.28 within
// [-pi, +pi] (+pi on the negative x axis, 0 for the zero vector). A bearing
// whose magnitude is below the angle_tolerance register (radians * 2^28, reset
// 80531 = atan(0.0003)) reads as zero; write cfg only while nothing is in
// flight. The block is a fixed pipeline: it accepts one item every cycle while
// polar is not stalled. Two input stages (capture, absolute value) feed both
// paths; the angle path sets the depth (3-stage normaliser, 31 CORDIC steps,
// rounding, then the quadrant and deadband stages) and the 32-stage square
// root (one root bit per stage) is padded by two stages to match. A stall on
// polar freezes the whole pipeline; vec.ready is low only while a result sits
// unaccepted at the output.
module cartesian_to_polar_deadband (
    input logic        clk,
    input logic        rst_n,
    c2p_vec_if.sink    vec,
    c2p_polar_if.source polar,
    c2p_cfg_if.sink    cfg
);
    import c2p_pkg::*;

    localparam int VLD_N    = PIPE_LAT + 2;
    localparam int FLAG_DLY = ANG_LAT + ANG_PAD;

    logic             en;
    logic [VLD_N-1:0] vld_reg;
    logic [VLD_N-1:0] vld_next;
    tol_t             tol_reg;

    // input and absolute-value stages
    coord_t    x_reg;
    coord_t    y_reg;
    abs_t      ax_reg;
    abs_t      ay_reg;
    abs_t      ax_next;
    abs_t      ay_next;
    quad_t     quad_reg;
    quad_t     quad_next;
    quad_t     quad_dly_reg [FLAG_DLY];

    // results of the two arithmetic units
    mag_t      mag_sq;
    mag_t      mag_out;
    fq_angle_t ang_fq;
    fq_angle_t ang_al;

    // quadrant and deadband stages
    fq_angle_t a_sel;
    tol_t      aq_next;
    tol_t      aq_reg;
    logic      yneg_reg;
    logic signed [ANG_W-1:0] aq_s;
    bearing_t  bearing_next;
    bearing_t  bearing_reg;

    // Whole pipeline moves together unless the output item is held.
    assign en        = !vld_reg[VLD_N-1] || polar.ready;
    assign vec.ready = en;
    assign cfg.ready = 1'b1;

    assign vld_next = {vld_reg[VLD_N-2:0], vec.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.angle_tolerance;
        end
    end

    // Absolute values; the most negative input maps to 2^(W-1) unsigned.
    always_comb
    begin
        ax_next           = x_reg[COORD_WIDTH-1] ? abs_t'(-x_reg) : abs_t'(x_reg);
        ay_next           = y_reg[COORD_WIDTH-1] ? abs_t'(-y_reg) : abs_t'(y_reg);
        quad_next.x_neg   = x_reg[COORD_WIDTH-1];
        quad_next.y_neg   = y_reg[COORD_WIDTH-1];
        quad_next.ax_zero = (x_reg == '0);
        quad_next.ay_zero = (y_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= vec.x_coord;
            y_reg    <= vec.y_coord;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            quad_reg <= quad_next;
            quad_dly_reg[0] <= quad_reg;
            for (int j = 1; j < FLAG_DLY; j++)
            begin
                quad_dly_reg[j] <= quad_dly_reg[j-1];
            end
        end
    end

    c2p_isqrt u_isqrt (
        .clk (clk),
        .en  (en),
        .ax  (ax_reg),
        .ay  (ay_reg),
        .mag (mag_sq)
    );

    c2p_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .angle (ang_fq)
    );

    // Balance the two paths so both fields of an item leave together.
    if (MAG_PAD > 0)
    begin : g_mag_pad
        mag_t mpad_reg [MAG_PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mpad_reg[0] <= mag_sq;
                for (int j = 1; j < MAG_PAD; j++)
                begin
                    mpad_reg[j] <= mpad_reg[j-1];
                end
            end
        end

        assign mag_out = mpad_reg[MAG_PAD-1];
    end
    else
    begin : g_mag_direct
        assign mag_out = mag_sq;
    end

    if (ANG_PAD > 0)
    begin : g_ang_pad
        fq_angle_t apad_reg [ANG_PAD];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                apad_reg[0] <= ang_fq;
                for (int j = 1; j < ANG_PAD; j++)
                begin
                    apad_reg[j] <= apad_reg[j-1];
                end
            end
        end

        assign ang_al = apad_reg[ANG_PAD-1];
    end
    else
    begin : g_ang_direct
        assign ang_al = ang_fq;
    end

    // Axis cases override the CORDIC angle: y zero (zero vector too) gives 0,
    // x zero gives pi/2. Negative x reflects about pi/2.
    always_comb
    begin
        if (quad_dly_reg[FLAG_DLY-1].ay_zero)
        begin
            a_sel = '0;
        end
        else if (quad_dly_reg[FLAG_DLY-1].ax_zero)
        begin
            a_sel = HALF_PI_Q28;
        end
        else
        begin
            a_sel = ang_al;
        end
        aq_next = quad_dly_reg[FLAG_DLY-1].x_neg ? (PI_Q28 - TOL_W'(a_sel)) : TOL_W'(a_sel);
    end

    // aq_reg is already |bearing|, so the deadband compare runs beside the negate.
    assign aq_s = signed'({1'b0, aq_reg});

    always_comb
    begin
        if (aq_reg < tol_reg)
        begin
            bearing_next = '0;
        end
        else if (yneg_reg)
        begin
            bearing_next = -aq_s;
        end
        else
        begin
            bearing_next = aq_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aq_reg      <= aq_next;
            yneg_reg    <= quad_dly_reg[FLAG_DLY-1].y_neg;
            bearing_reg <= bearing_next;
        end
    end

    assign polar.valid     = vld_reg[VLD_N-1];
    assign polar.magnitude = mag_out;
    assign polar.bearing   = bearing_reg;

endmodule

FILE: sv/c2p_checker.sv
`include "cartesian_to_polar_deadband_defines.svh"

module c2p_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              vec_ready,
    input logic              polar_valid,
    input logic              polar_ready,
    input c2p_pkg::mag_t     magnitude,
    input c2p_pkg::bearing_t bearing
);
    import c2p_pkg::*;

    // held result must not vanish
    `C2P_ASSERT(a_out_hold, polar_valid && !polar_ready |=> polar_valid, "result lost under stall")

    // input side only waits on a held result
    `C2P_ASSERT(a_ready_link, vec_ready == (!polar_valid || polar_ready), "vec.ready mismatch")

    // only the zero vector has zero length, and its bearing is zero
    `C2P_ASSERT(a_zero_len, polar_valid && magnitude == '0 |-> bearing == '0, "zero vector bearing")

    `C2P_ASSERT(a_bearing_rng, polar_valid |-> bearing <= BEARING_MAX && bearing >= BEARING_MIN, "bearing beyond pi")

endmodule

bind cartesian_to_polar_deadband c2p_checker u_c2p_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .vec_ready   (vec.ready),
    .polar_valid (polar.valid),
    .polar_ready (polar.ready),
    .magnitude   (polar.magnitude),
    .bearing     (polar.bearing)
);
